@@ rtl/core/lsas_pkg.sv @@
// shared types and constants of the light sensor autoscale smoother
package lsas_pkg;

	localparam int SAMPLE_W  = 10;
	localparam int LEVEL_W   = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 10;

	// shared divider: quotient always below 2**QUO_W
	localparam int QUO_W = 7;
	localparam int NUM_W = 17;
	localparam int DEN_W = 10;
	localparam int CNT_W = 3;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;
	localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 7'd100;
	localparam logic [NUM_W-1:0]    MAP_SCALE  = 17'd100;

	typedef enum logic [1:0] {
		REG_AUTOSCALE   = 2'd0,
		REG_MANUAL_LOW  = 2'd1,
		REG_MANUAL_HIGH = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_MAP,
		S_DIV_MAP,
		S_ACC,
		S_DIV_MEAN,
		S_DONE
	} state_t;

endpackage

@@ rtl/core/lsas_if.sv @@
// beat channels of the light sensor autoscale smoother
interface lsas_sample_if;
	logic                          valid;
	logic                          ready;
	logic [lsas_pkg::SAMPLE_W-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface lsas_level_if;
	logic                         valid;
	logic                         ready;
	logic [lsas_pkg::LEVEL_W-1:0] level;
	modport source (output valid, output level, input ready);
	modport sink (input valid, input level, output ready);
endinterface

interface lsas_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lsas_pkg::CFG_IDX_W-1:0] index;
	logic [lsas_pkg::CFG_DAT_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/light_sensor_autoscale_smoother.sv @@
// autoranging moving-average brightness filter with a shared serial divider
//
// channel   dir  payload               beat
// cfg       in   index[1:0] data[9:0]  valid & ready, ready always high
// samples   in   sample[9:0]           valid & ready, ready only when idle
// levels    out  level[6:0]            valid & ready, held in output register
//
// a new sample runs the shared 7-step restoring divider once for the mapping
// and once for the mean; a repeated sample skips both and reuses the held level
// the next sample is taken while a finished level waits in the output register
// levels back-pressure stalls only the hand-over of the next result
// asynchronous reset clears bounds, history fill count, sum and held level
module light_sensor_autoscale_smoother #(
	parameter int MEAN_DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lsas_cfg_if.sink             cfg,
	lsas_sample_if.sink          samples,
	lsas_level_if.source         levels
);

	localparam int SLOT_W = (MEAN_DEPTH > 1) ? $clog2(MEAN_DEPTH) : 1;
	localparam int FILL_W = $clog2(MEAN_DEPTH + 1);
	localparam int SUM_W  = $clog2(100 * MEAN_DEPTH + 1);

	lsas_pkg::state_t state_q, state_d;

	logic                          mode_q;
	logic [lsas_pkg::SAMPLE_W-1:0] man_low_q, man_high_q;

	logic [lsas_pkg::SAMPLE_W-1:0] prev_q, trk_low_q, trk_high_q;
	logic [lsas_pkg::SAMPLE_W-1:0] v_q, lo_q, hi_q;
	logic                          rep_q;

	logic [lsas_pkg::NUM_W-1:0] rem_q, shifted;
	logic [lsas_pkg::DEN_W-1:0] den_q;
	logic [lsas_pkg::QUO_W-1:0] quo_q;
	logic [lsas_pkg::CNT_W-1:0] cnt_q;

	logic [lsas_pkg::LEVEL_W-1:0] mem [MEAN_DEPTH];
	logic [lsas_pkg::LEVEL_W-1:0] rd_q, old_val, mapped;
	logic [SLOT_W-1:0]            slot_q;
	logic [FILL_W-1:0]            fill_q;
	logic [SUM_W-1:0]             sum_q, sum_n;
	logic [lsas_pkg::LEVEL_W-1:0] held_q, level_q;
	logic                         out_valid_q;

	logic in_beat, out_free, mem_we, div_last;

	assign in_beat   = samples.valid && samples.ready;
	assign out_free  = !out_valid_q || levels.ready;
	assign div_last  = (cnt_q == '0);
	assign shifted   = lsas_pkg::NUM_W'(den_q) << cnt_q;
	assign mapped    = lsas_pkg::LEVEL_MAX - quo_q;
	assign old_val   = (fill_q > FILL_W'(slot_q)) ? rd_q : '0;
	assign sum_n     = sum_q - SUM_W'(old_val) + SUM_W'(mapped);

	assign cfg.ready    = 1'b1;
	assign levels.valid = out_valid_q;
	assign levels.level = level_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b1;
			man_low_q  <= '0;
			man_high_q <= lsas_pkg::SAMPLE_MAX;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				lsas_pkg::REG_AUTOSCALE:   mode_q     <= cfg.data[0];
				lsas_pkg::REG_MANUAL_LOW:  man_low_q  <= cfg.data;
				lsas_pkg::REG_MANUAL_HIGH: man_high_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsas_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		mem_we        = 1'b0;
		case (state_q)
			lsas_pkg::S_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					state_d = (samples.sample == prev_q) ? lsas_pkg::S_DONE : lsas_pkg::S_CALC;
				end
			end
			lsas_pkg::S_CALC:     state_d = lsas_pkg::S_MAP;
			lsas_pkg::S_MAP:      state_d = lsas_pkg::S_DIV_MAP;
			lsas_pkg::S_DIV_MAP: begin
				if (div_last) begin
					state_d = lsas_pkg::S_ACC;
				end
			end
			lsas_pkg::S_ACC: begin
				mem_we  = 1'b1;
				state_d = lsas_pkg::S_DIV_MEAN;
			end
			lsas_pkg::S_DIV_MEAN: begin
				if (div_last) begin
					state_d = lsas_pkg::S_DONE;
				end
			end
			lsas_pkg::S_DONE: begin
				if (out_free) begin
					state_d = lsas_pkg::S_IDLE;
				end
			end
			default: state_d = lsas_pkg::S_IDLE;
		endcase
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			trk_low_q   <= lsas_pkg::SAMPLE_MAX;
			trk_high_q  <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_beat && samples.sample != prev_q) begin
				prev_q <= samples.sample;
			end
			if (state_q == lsas_pkg::S_CALC && mode_q) begin
				if (v_q < trk_low_q) begin
					trk_low_q <= v_q;
				end
				if (v_q > trk_high_q) begin
					trk_high_q <= v_q;
				end
			end
			if (state_q == lsas_pkg::S_ACC) begin
				sum_q  <= sum_n;
				slot_q <= (slot_q == SLOT_W'(MEAN_DEPTH - 1)) ? '0 : slot_q + 1'b1;
				if (fill_q != FILL_W'(MEAN_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (state_q == lsas_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
				if (!rep_q) begin
					held_q <= quo_q;
				end
			end else if (levels.valid && levels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath and shared divider
	always_ff @(posedge clk) begin
		case (state_q)
			lsas_pkg::S_IDLE: begin
				v_q   <= samples.sample;
				rep_q <= (samples.sample == prev_q);
			end
			lsas_pkg::S_CALC: begin
				if (mode_q) begin
					lo_q <= (v_q < trk_low_q) ? v_q : trk_low_q;
					hi_q <= (v_q > trk_high_q) ? v_q : trk_high_q;
				end else begin
					lo_q <= man_low_q;
					hi_q <= man_high_q;
					if (v_q < man_low_q) begin
						v_q <= man_low_q;
					end else if (v_q > man_high_q) begin
						v_q <= man_high_q;
					end
				end
			end
			lsas_pkg::S_MAP: begin
				quo_q <= '0;
				cnt_q <= lsas_pkg::CNT_W'(lsas_pkg::QUO_W - 1);
				if (hi_q > lo_q) begin
					rem_q <= lsas_pkg::NUM_W'(v_q - lo_q) * lsas_pkg::MAP_SCALE;
					den_q <= hi_q - lo_q;
				end else begin
					rem_q <= '0;
					den_q <= lsas_pkg::DEN_W'(1);
				end
			end
			lsas_pkg::S_ACC: begin
				quo_q <= '0;
				cnt_q <= lsas_pkg::CNT_W'(lsas_pkg::QUO_W - 1);
				rem_q <= lsas_pkg::NUM_W'(sum_n);
				den_q <= lsas_pkg::DEN_W'(MEAN_DEPTH);
			end
			lsas_pkg::S_DIV_MAP, lsas_pkg::S_DIV_MEAN: begin
				if (rem_q >= shifted) begin
					rem_q        <= rem_q - shifted;
					quo_q[cnt_q] <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
			lsas_pkg::S_DONE: begin
				if (out_free) begin
					level_q <= rep_q ? held_q : quo_q;
				end
			end
			default: ;
		endcase
	end

	// history ring
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_q] <= mapped;
		end
		rd_q <= mem[slot_q];
	end

endmodule

@@ rtl/core/lsas_checker.sv @@
// port checker for the light sensor autoscale smoother and its bind
module lsas_port_checks (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [lsas_pkg::LEVEL_W-1:0] level
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level))
		else $error("stalled level beat changed or dropped");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken on consecutive cycles");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level <= lsas_pkg::LEVEL_MAX)
		else $error("level above full scale");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(out_valid) && $past(in_ready) && !$past(in_valid && in_ready) |-> !out_valid)
		else $error("level beat without a sample");

endmodule

bind light_sensor_autoscale_smoother lsas_port_checks u_lsas_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (levels.valid),
	.out_ready (levels.ready),
	.level     (levels.level)
);
